/* rtl/core/lseg_pkg.sv */
`timescale 1ns / 1ps
// Package for the left-shift binary extended GCD block.
// Holds shared constants, the controller state and datapath op types, the command/status structs and a top-bit helper.
package lseg_pkg;

    localparam int LSEG_WIDTH = 64;
    localparam int DW         = 64;

    typedef enum logic [3:0] {
        S_IDLE, S_LOAD, S_TEST, S_KCALC, S_ROUND, S_CHECK, S_DIV, S_QFIX, S_MUL, S_FIN
    } state_t;

    typedef enum logic [3:0] {
        DP_NOP, DP_CAPTURE, DP_LOAD, DP_KCALC, DP_ROUND, DP_DIVINIT, DP_DIVSTEP,
        DP_QFIX, DP_MUL, DP_FINISH
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } cmd_t;

    typedef struct packed {
        logic err;
        logic v3_zero;
        logic simple;
        logic div_last;
        logic mul_last;
    } status_t;

    // Index of the highest set bit, zero for a zero word.
    function automatic logic [5:0] top_bit(input logic [DW-1:0] x);
        logic [5:0] n;
        n = '0;
        for (int i = 0; i < DW; i++) begin
            if (x[i]) n = 6'(i);
        end
        return n;
    endfunction

endpackage

/* rtl/core/lseg_ctrl.sv */
`timescale 1ns / 1ps
// Sequencer for the extended GCD: reduction rounds, division, multiply and output.
// Depends on lseg_pkg.
module lseg_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    output logic            m_tvalid,
    input  logic            m_tready,
    input  lseg_pkg::status_t sts,
    output lseg_pkg::cmd_t  cmd
);
    import lseg_pkg::*;

    state_t state_reg, state_next;
    logic   mvalid_reg, mvalid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = mvalid_reg;

    always_comb begin
        state_next  = state_reg;
        mvalid_next = mvalid_reg && !m_tready;
        cmd.op      = DP_NOP;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.op     = DP_CAPTURE;
                    state_next = S_LOAD;
                end
            end
            S_LOAD: begin
                cmd.op     = DP_LOAD;
                state_next = sts.err ? S_FIN : S_TEST;
            end
            S_TEST:  state_next = sts.v3_zero ? S_CHECK : S_KCALC;
            S_KCALC: begin
                cmd.op     = DP_KCALC;
                state_next = S_ROUND;
            end
            S_ROUND: begin
                cmd.op     = DP_ROUND;
                state_next = S_TEST;
            end
            S_CHECK: begin
                if (sts.simple) begin
                    state_next = S_FIN;
                end else begin
                    cmd.op     = DP_DIVINIT;
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                cmd.op = DP_DIVSTEP;
                if (sts.div_last) state_next = S_QFIX;
            end
            S_QFIX: begin
                cmd.op     = DP_QFIX;
                state_next = S_MUL;
            end
            S_MUL: begin
                cmd.op = DP_MUL;
                if (sts.mul_last) state_next = S_FIN;
            end
            S_FIN: begin
                // The output register must be free before it is loaded.
                if (!mvalid_reg || m_tready) begin
                    cmd.op      = DP_FINISH;
                    mvalid_next = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

/* rtl/core/lseg_dp.sv */
`timescale 1ns / 1ps
// Datapath for the extended GCD: remainder/coefficient registers, restoring
// divider, 32x32 multiplier sequence and result register. Depends on lseg_pkg.
module lseg_dp #(
    parameter int WIDTH = lseg_pkg::LSEG_WIDTH
) (
    input  logic              aclk,
    input  lseg_pkg::cmd_t    cmd,
    output lseg_pkg::status_t sts,
    input  logic [63:0]       in_a,
    input  logic [63:0]       in_b,
    output logic [62:0]       out_gcd,
    output logic [63:0]       out_s,
    output logic [63:0]       out_t,
    output logic              out_err
);
    import lseg_pkg::*;

    localparam logic [DW-1:0] MINV = ~({DW{1'b1}} >> (DW + 1 - WIDTH));

    logic signed [WIDTH-1:0] aw, bw;
    logic [DW-1:0] a_reg, b_reg, aa_reg, ab_reg;
    logic an_reg, bn_reg, err_reg;
    logic [DW-1:0] u1_reg, u2_reg, u3_reg, v1_reg, v2_reg, v3_reg;
    logic [5:0]    k_reg;
    logic [DW-1:0] rem_reg, quo_reg, dvs_reg, q_reg, mb_reg, ma_reg;
    logic          qneg_reg;
    logic [5:0]    dcnt_reg;
    logic [1:0]    mcnt_reg;
    logic [62:0]   gcd_reg;
    logic [DW-1:0] s_reg, t_reg;
    logic          rerr_reg;

    assign aw = in_a[WIDTH-1:0];
    assign bw = in_b[WIDTH-1:0];

    // Shift estimate for the current round.
    logic [5:0]    k_est;
    logic [DW-1:0] v3_est;
    assign k_est  = top_bit(u3_reg) - top_bit(v3_reg);
    assign v3_est = v3_reg << k_est;

    // Round arithmetic.
    logic [DW-1:0] sh, da, db, n3, n2, n1;
    logic [6:0]    k1;
    logic          pick_a;
    assign k1     = {1'b0, k_reg} + 7'd1;
    assign sh     = v3_reg << k_reg;
    assign da     = u3_reg - sh;
    assign db     = (sh << 1) - u3_reg;
    assign pick_a = da < db;
    assign n3     = pick_a ? da : db;
    assign n2     = pick_a ? (u2_reg - (v2_reg << k_reg)) : ((v2_reg << k1) - u2_reg);
    assign n1     = pick_a ? (u1_reg - (v1_reg << k_reg)) : ((v1_reg << k1) - u1_reg);

    // Restoring divider step.
    logic [DW:0] trial;
    assign trial = {1'b0, rem_reg[DW-2:0], quo_reg[DW-1]} - {1'b0, dvs_reg};

    // One 32x32 partial product per cycle on each operand.
    logic [31:0] mq, mbx, max_;
    logic [63:0] pb, pa;
    always_comb begin
        case (mcnt_reg)
            2'd0:    begin mq = q_reg[31:0];  mbx = b_reg[31:0];  max_ = a_reg[31:0];  end
            2'd1:    begin mq = q_reg[63:32]; mbx = b_reg[31:0];  max_ = a_reg[31:0];  end
            default: begin mq = q_reg[31:0];  mbx = b_reg[63:32]; max_ = a_reg[63:32]; end
        endcase
    end
    assign pb = mq * mbx;
    assign pa = mq * max_;

    logic [DW-1:0] rs_c, rt_c, rs_f, rt_f;
    assign rs_c = u1_reg - mb_reg;
    assign rt_c = u2_reg + ma_reg;

    always_comb begin
        if (u3_reg == aa_reg) begin
            rs_f = an_reg ? {DW{1'b1}} : 64'd1;
            rt_f = '0;
        end else if (u3_reg == ab_reg) begin
            rs_f = '0;
            rt_f = bn_reg ? {DW{1'b1}} : 64'd1;
        end else begin
            rs_f = an_reg ? (64'd0 - rs_c) : rs_c;
            rt_f = bn_reg ? (64'd0 - rt_c) : rt_c;
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd.op)
            DP_CAPTURE: begin
                a_reg <= 64'(aw);
                b_reg <= 64'(bw);
            end
            DP_LOAD: begin
                an_reg  <= a_reg[DW-1];
                bn_reg  <= b_reg[DW-1];
                err_reg <= (a_reg == MINV) || (b_reg == MINV);
                aa_reg  <= a_reg[DW-1] ? (64'd0 - a_reg) : a_reg;
                ab_reg  <= b_reg[DW-1] ? (64'd0 - b_reg) : b_reg;
                if ((a_reg[DW-1] ? (64'd0 - a_reg) : a_reg) <
                    (b_reg[DW-1] ? (64'd0 - b_reg) : b_reg)) begin
                    u1_reg <= 64'd0; u2_reg <= 64'd1;
                    u3_reg <= b_reg[DW-1] ? (64'd0 - b_reg) : b_reg;
                    v1_reg <= 64'd1; v2_reg <= 64'd0;
                    v3_reg <= a_reg[DW-1] ? (64'd0 - a_reg) : a_reg;
                end else begin
                    u1_reg <= 64'd1; u2_reg <= 64'd0;
                    u3_reg <= a_reg[DW-1] ? (64'd0 - a_reg) : a_reg;
                    v1_reg <= 64'd0; v2_reg <= 64'd1;
                    v3_reg <= b_reg[DW-1] ? (64'd0 - b_reg) : b_reg;
                end
            end
            DP_KCALC: k_reg <= (v3_est > u3_reg) ? (k_est - 6'd1) : k_est;
            DP_ROUND: begin
                // u takes the larger of v and the new remainder, v the other.
                if (v3_reg < n3) begin
                    u1_reg <= n1;     u2_reg <= n2;     u3_reg <= n3;
                    v1_reg <= v1_reg; v2_reg <= v2_reg; v3_reg <= v3_reg;
                end else begin
                    u1_reg <= v1_reg; u2_reg <= v2_reg; u3_reg <= v3_reg;
                    v1_reg <= n1;     v2_reg <= n2;     v3_reg <= n3;
                end
            end
            DP_DIVINIT: begin
                rem_reg  <= '0;
                quo_reg  <= u1_reg[DW-1] ? (64'd0 - u1_reg) : u1_reg;
                dvs_reg  <= ab_reg;
                qneg_reg <= u1_reg[DW-1] ^ b_reg[DW-1];
                dcnt_reg <= '0;
            end
            DP_DIVSTEP: begin
                dcnt_reg <= dcnt_reg + 6'd1;
                if (!trial[DW]) begin
                    rem_reg <= trial[DW-1:0];
                    quo_reg <= {quo_reg[DW-2:0], 1'b1};
                end else begin
                    rem_reg <= {rem_reg[DW-2:0], quo_reg[DW-1]};
                    quo_reg <= {quo_reg[DW-2:0], 1'b0};
                end
            end
            DP_QFIX: begin
                q_reg    <= qneg_reg ? (64'd0 - quo_reg) : quo_reg;
                mb_reg   <= '0;
                ma_reg   <= '0;
                mcnt_reg <= '0;
            end
            DP_MUL: begin
                mcnt_reg <= mcnt_reg + 2'd1;
                if (mcnt_reg == 2'd0) begin
                    mb_reg <= pb;
                    ma_reg <= pa;
                end else begin
                    mb_reg <= mb_reg + {pb[31:0], 32'd0};
                    ma_reg <= ma_reg + {pa[31:0], 32'd0};
                end
            end
            DP_FINISH: begin
                rerr_reg <= err_reg;
                gcd_reg  <= err_reg ? '0 : u3_reg[62:0];
                s_reg    <= err_reg ? '0 : rs_f;
                t_reg    <= err_reg ? '0 : rt_f;
            end
            default: ;
        endcase
    end

    assign sts.err      = (a_reg == MINV) || (b_reg == MINV);
    assign sts.v3_zero  = (v3_reg == '0);
    assign sts.simple   = (u3_reg == aa_reg) || (u3_reg == ab_reg);
    assign sts.div_last = (dcnt_reg == 6'd63);
    assign sts.mul_last = (mcnt_reg == 2'd2);

    assign out_gcd = gcd_reg;
    assign out_s   = s_reg;
    assign out_t   = t_reg;
    assign out_err = rerr_reg;

endmodule

/* rtl/core/left_shift_extended_gcd.sv */
`timescale 1ns / 1ps
// Left-shift binary extended GCD: one transfer in, one result transfer out.
// The number of reduction rounds is data dependent; when needed, a 64-step divider,
// a quotient fix and a 3-step multiply follow the rounds.
// One item at a time; the reduction loop and the serial divider set the rate.
// aresetn is synchronous and active low and clears the controller and output valid.
module left_shift_extended_gcd #(
    parameter int WIDTH = lseg_pkg::LSEG_WIDTH
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // a[63:0], b[127:64]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [191:0] m_tdata,   // gcd[62:0], coef_s[126:63], coef_t[190:127], zero pad
    output logic         m_tuser    // range_error
);
    import lseg_pkg::*;

    cmd_t    cmd;
    status_t sts;
    logic [62:0] gcd;
    logic [63:0] cs, ct;

    lseg_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .sts(sts), .cmd(cmd)
    );

    lseg_dp #(.WIDTH(WIDTH)) u_dp (
        .aclk(aclk), .cmd(cmd), .sts(sts), .in_a(s_tdata[63:0]), .in_b(s_tdata[127:64]),
        .out_gcd(gcd), .out_s(cs), .out_t(ct), .out_err(m_tuser)
    );

    assign m_tdata = {1'b0, ct, cs, gcd};

`ifndef ASSERT_OFF
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == '0) else $error("error result not cleared");
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready) else $error("accepted while busy");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result dropped");
`endif

endmodule
